// ----- src/lcats_pkg.sv -----
// shared constants, codes and saturation helpers for the load cell averaging block
package lcats_pkg;

  localparam int WINDOW_DEF      = 10;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int KW_W    = 24;   // known weight width
  localparam int WGT_W   = 40;
  localparam int AVG_W   = 24;
  localparam int SCL_W   = 32;
  localparam int STAT_W  = 3;
  localparam int MODE_W  = 3;
  localparam int ALPHA_W = 16;
  localparam int MCD_W   = 23;
  localparam int MSC_W   = 31;
  localparam int STEP_W  = 16;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 31;
  localparam int MB_W    = 32;   // multiplier second operand width
  localparam int DIVN_W  = KW_W + 25; // calibration numerator width
  localparam int OUT_W   = 128;

  localparam logic [MODE_W-1:0] MODE_SAMPLE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TARE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CAL    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UP     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DOWN   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_SAMPLE = 3'd1;
  localparam logic [STAT_W-1:0] ST_ZERO_WGT  = 3'd2;
  localparam logic [STAT_W-1:0] ST_SMALL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_CAL   = 3'd4;

  localparam logic [CFG_IW-1:0] CFG_ALPHA     = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_MIN_DELTA = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_MIN_SCALE = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_STEP      = 3'd3;

  // apply sign to a magnitude, clamped to 32 bit signed
  function automatic logic [SCL_W-1:0] sat32(input logic [63:0] m, input logic neg);
    logic [63:0] lim;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (m > lim) m = lim;
    return neg ? SCL_W'(64'd0 - m) : SCL_W'(m);
  endfunction

  // apply sign to a magnitude, clamped to 40 bit signed
  function automatic logic [WGT_W-1:0] sat40(input logic [63:0] m, input logic neg);
    logic [63:0] lim;
    lim = neg ? 64'h80_0000_0000 : 64'h7F_FFFF_FFFF;
    if (m > lim) m = lim;
    return neg ? WGT_W'(64'd0 - m) : WGT_W'(m);
  endfunction

endpackage

// ----- src/lcats_mul.sv -----
// bit-serial shift-add multiplier, one bit of b per cycle
module lcats_mul #(
  parameter int AW = 34,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             busy,
  output logic             done,
  output logic [AW+BW-1:0] prod
);
  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0]    a_r;
  logic [AW+BW-1:0] prod_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [AW:0]      sum;

  assign sum = {1'b0, prod_r[AW+BW-1:BW]} + (prod_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(BW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= a;
      prod_r <= {AW'(0), b};
    end else if (busy_r) begin
      prod_r <= {sum, prod_r[BW-1:1]};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = prod_r;
endmodule

// ----- src/lcats_div.sv -----
// restoring divider, one quotient bit per cycle
module lcats_div #(
  parameter int NW = 49,
  parameter int DW = 34
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_r;
  logic [DW-1:0] rem_r, den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   shifted, diff;
  logic          ge;

  assign shifted = {rem_r, num_r[NW-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      num_r <= {num_r[NW-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = num_r;
endmodule

// ----- src/load_cell_average_tare_scale.sv -----
// load cell moving average, exponential filter, tare and calibration top level
// a sample passes the divider for the average, the multiplier for the filter and the multiplier
// for the weight; tare and unused modes go straight to the weight multiply, calibrate divides
// first and scale adjust multiplies first; while uncalibrated the weight multiply is skipped
// and the first sample skips the filter
// the result register frees the input side while a result waits; sync active-low reset
module load_cell_average_tare_scale #(
  parameter int WINDOW      = lcats_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = lcats_pkg::SAMPLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // raw_sample, known_weight
  input  logic [((SAMPLE_BITS+lcats_pkg::KW_W+7)/8)*8-1:0] in_tdata,
  // mode
  input  logic [lcats_pkg::MODE_W-1:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // weight, average_raw, tare_value, scale_value, calibrated, status
  output logic [lcats_pkg::OUT_W-1:0] out_tdata,
  input  logic cfg_we,
  input  logic [lcats_pkg::CFG_IW-1:0] cfg_index,
  input  logic [lcats_pkg::CFG_DW-1:0] cfg_wdata
);
  localparam int SB  = SAMPLE_BITS;
  localparam int SW  = SB + 4;
  localparam int FW  = SB + 9;
  localparam int DW  = SB + 10;
  localparam int MA  = (DW > 32) ? DW : 32;
  localparam int PW  = MA + lcats_pkg::MB_W;
  localparam int NW  = lcats_pkg::DIVN_W;
  localparam int FCW = $clog2(WINDOW + 1);
  localparam int IW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_AVG  = 8'b0000_0010,
    S_FILT = 8'b0000_0100,
    S_CAL  = 8'b0000_1000,
    S_ADJ  = 8'b0001_0000,
    S_WST  = 8'b0010_0000,
    S_WGT  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [lcats_pkg::ALPHA_W-1:0] alpha_r;
  logic [lcats_pkg::MCD_W-1:0]   mincal_r;
  logic [lcats_pkg::MSC_W-1:0]   minscale_r;
  logic [lcats_pkg::STEP_W-1:0]  step_r;

  logic signed [SB-1:0] store_r [WINDOW];
  logic [FCW-1:0]       fill_r;
  logic [IW-1:0]        wi_r;
  logic signed [SW-1:0] sum_r;
  logic signed [SB-1:0] avg_r, tare_r;
  logic signed [FW-1:0] filt_r;
  logic signed [lcats_pkg::SCL_W-1:0] scale_r;
  logic cal_r, hs_r, hf_r, sgn_r;
  logic [lcats_pkg::STAT_W-1:0] status_r;
  logic [lcats_pkg::WGT_W-1:0]  wgt_r;
  logic out_valid_r;
  logic [lcats_pkg::OUT_W-1:0] out_data_r;

  logic accept, full;
  logic [lcats_pkg::MODE_W-1:0] mode;
  logic signed [SB-1:0] raw;
  logic [lcats_pkg::KW_W-1:0] kw;
  logic signed [SW-1:0] old_x, raw_x, sum_new;
  logic [SW-1:0] sum_mag;
  logic [FCW-1:0] fill_new;
  logic signed [DW-1:0] d, filt_x, tare_x, avg_x, diff;
  logic [DW-1:0] ud, udiff;
  logic signed [SB-1:0] avg_new;
  logic [47:0] mincal_x;

  logic mul_start, mul_busy, mul_done;
  logic [MA-1:0] mul_a;
  logic [lcats_pkg::MB_W-1:0] mul_b;
  logic [PW-1:0] mul_p;
  logic div_start, div_busy, div_done;
  logic [NW-1:0] div_num, div_q;
  logic [DW-1:0] div_den;

  logic signed [PW:0] fprod;
  logic signed [PW-16:0] fstep;
  logic [PW:0] wsum;
  logic [47:0] adj_sum;
  logic [47:0] adj_m;
  logic [lcats_pkg::SCL_W-1:0] scale_mag;

  assign mode   = in_tuser;
  assign raw    = $signed(in_tdata[SB-1:0]);
  assign kw     = in_tdata[SB +: lcats_pkg::KW_W];
  assign accept = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign full   = (fill_r == FCW'(WINDOW));

  assign old_x    = SW'(store_r[wi_r]);
  assign raw_x    = SW'(raw);
  assign sum_new  = sum_r - (full ? old_x : SW'(0)) + raw_x;
  assign sum_mag  = sum_new[SW-1] ? SW'(-sum_new) : SW'(sum_new);
  assign fill_new = full ? fill_r : fill_r + 1'b1;

  assign filt_x = DW'(filt_r);
  assign tare_x = DW'(tare_r);
  assign d      = filt_x - (tare_x <<< 8);
  assign ud     = d[DW-1] ? DW'(-d) : DW'(d);
  assign mincal_x = {17'd0, mincal_r, 8'd0};

  // quotient of the average division with the sum's sign put back
  assign avg_new = sgn_r ? SB'(-$signed({1'b0, div_q[SB-1:0]})) : SB'(div_q[SB-1:0]);
  assign avg_x   = DW'(avg_new);
  assign diff    = (avg_x <<< 8) - filt_x;
  assign udiff   = diff[DW-1] ? DW'(-diff) : DW'(diff);

  assign scale_mag = scale_r[lcats_pkg::SCL_W-1] ? lcats_pkg::SCL_W'(-scale_r)
                                                 : lcats_pkg::SCL_W'(scale_r);

  assign fprod   = sgn_r ? -$signed({1'b0, mul_p}) : $signed({1'b0, mul_p});
  assign fstep   = (PW-15)'((fprod + $signed((PW+1)'(32768))) >>> 16);
  assign wsum    = {1'b0, mul_p} + (PW+1)'(1 << 23);
  assign adj_sum = 48'(mul_p) + 48'd32768;
  assign adj_m   = ((adj_sum >> 16) < 48'(minscale_r)) ? 48'(minscale_r) : (adj_sum >> 16);

  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_WST;
          priority if (mode == lcats_pkg::MODE_SAMPLE) begin
            div_start = 1'b1;
            div_num   = NW'(sum_mag);
            div_den   = DW'(fill_new);
            state_nxt = S_AVG;
          end else if (mode == lcats_pkg::MODE_CAL) begin
            if (hs_r && kw != '0 && ud != '0 && 48'(ud) >= mincal_x) begin
              div_start = 1'b1;
              div_num   = NW'({kw, 24'd0}) + NW'(ud >> 1);
              div_den   = ud;
              state_nxt = S_CAL;
            end
          end else if (mode == lcats_pkg::MODE_UP || mode == lcats_pkg::MODE_DOWN) begin
            if (cal_r) begin
              mul_start = 1'b1;
              mul_a     = MA'(scale_mag);
              mul_b     = (mode == lcats_pkg::MODE_UP) ? 32'd65536 + 32'(step_r)
                                                       : 32'd65536 - 32'(step_r);
              state_nxt = S_ADJ;
            end
          end else begin
          end
        end
      end
      S_AVG: begin
        if (div_done) begin
          if (hf_r) begin
            mul_start = 1'b1;
            mul_a     = MA'(udiff);
            mul_b     = 32'(alpha_r);
            state_nxt = S_FILT;
          end else begin
            state_nxt = S_WST;
          end
        end
      end
      S_FILT: if (mul_done) state_nxt = S_WST;
      S_CAL:  if (div_done) state_nxt = S_WST;
      S_ADJ:  if (mul_done) state_nxt = S_WST;
      S_WST: begin
        if (cal_r) begin
          mul_start = 1'b1;
          mul_a     = MA'(ud);
          mul_b     = scale_mag;
          state_nxt = S_WGT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_WGT:  if (mul_done) state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      alpha_r     <= 16'd13107;
      mincal_r    <= 23'd100;
      minscale_r  <= 31'd16777;
      step_r      <= 16'd655;
      fill_r      <= '0;
      wi_r        <= '0;
      sum_r       <= '0;
      avg_r       <= '0;
      filt_r      <= '0;
      tare_r      <= '0;
      scale_r     <= '0;
      cal_r       <= 1'b0;
      hs_r        <= 1'b0;
      hf_r        <= 1'b0;
      sgn_r       <= 1'b0;
      status_r    <= lcats_pkg::ST_OK;
      wgt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          lcats_pkg::CFG_ALPHA:     alpha_r    <= cfg_wdata[lcats_pkg::ALPHA_W-1:0];
          lcats_pkg::CFG_MIN_DELTA: mincal_r   <= cfg_wdata[lcats_pkg::MCD_W-1:0];
          lcats_pkg::CFG_MIN_SCALE: minscale_r <= cfg_wdata[lcats_pkg::MSC_W-1:0];
          lcats_pkg::CFG_STEP:      step_r     <= cfg_wdata[lcats_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            status_r <= lcats_pkg::ST_OK;
            priority if (mode == lcats_pkg::MODE_SAMPLE) begin
              sum_r  <= sum_new;
              fill_r <= fill_new;
              wi_r   <= (wi_r == IW'(WINDOW - 1)) ? '0 : wi_r + 1'b1;
              hs_r   <= 1'b1;
              sgn_r  <= sum_new[SW-1];
            end else if (mode == lcats_pkg::MODE_TARE) begin
              if (hs_r) tare_r <= avg_r;
              else status_r <= lcats_pkg::ST_NO_SAMPLE;
            end else if (mode == lcats_pkg::MODE_CAL) begin
              sgn_r <= d[DW-1];
              priority if (!hs_r) status_r <= lcats_pkg::ST_NO_SAMPLE;
              else if (kw == '0) status_r <= lcats_pkg::ST_ZERO_WGT;
              else if (ud == '0 || 48'(ud) < mincal_x) status_r <= lcats_pkg::ST_SMALL;
              else ;
            end else if (mode == lcats_pkg::MODE_UP || mode == lcats_pkg::MODE_DOWN) begin
              sgn_r <= scale_r[lcats_pkg::SCL_W-1];
              if (!cal_r) status_r <= lcats_pkg::ST_NOT_CAL;
            end else begin
            end
          end
        end
        S_AVG: begin
          if (div_done) begin
            avg_r <= avg_new;
            sgn_r <= diff[DW-1];
            if (!hf_r) begin
              filt_r <= FW'(avg_x <<< 8);
              hf_r   <= 1'b1;
            end
          end
        end
        S_FILT: if (mul_done) filt_r <= filt_r + FW'(fstep);
        S_CAL: begin
          if (div_done) begin
            scale_r <= lcats_pkg::sat32(64'(div_q), sgn_r);
            cal_r   <= 1'b1;
          end
        end
        S_ADJ: if (mul_done) scale_r <= lcats_pkg::sat32(64'(adj_m), sgn_r);
        S_WST: begin
          wgt_r <= '0;
          sgn_r <= d[DW-1] ^ scale_r[lcats_pkg::SCL_W-1];
        end
        S_WGT: if (mul_done) wgt_r <= lcats_pkg::sat40(64'(wsum >> 24), sgn_r);
        S_OUT: ;
        default: ;
      endcase
      if (state_r == S_OUT && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // window ring, entries read only once written
  always_ff @(posedge clk) begin
    if (accept && mode == lcats_pkg::MODE_SAMPLE) store_r[wi_r] <= raw;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
      out_data_r <= {4'd0, status_r, cal_r, scale_r,
                     lcats_pkg::AVG_W'(tare_r), lcats_pkg::AVG_W'(avg_r), wgt_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  lcats_div #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .done(div_done), .quo(div_q)
  );

  lcats_mul #(.AW(MA), .BW(lcats_pkg::MB_W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .busy(mul_busy), .done(mul_done), .prod(mul_p)
  );

  a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !mul_busy && !div_busy) else $error("unit busy while idle");
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FCW'(WINDOW)) else $error("fill count beyond window");
  a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cal_r) |-> cal_r) else $error("calibration flag dropped");
endmodule
